// ===== src/bmp_stream_to_rgba_core_macros.svh =====
// Assertion helpers for the BMP stream decoder.
`ifndef BMP_STREAM_TO_RGBA_CORE_MACROS_SVH
`define BMP_STREAM_TO_RGBA_CORE_MACROS_SVH

// Checked at every edge out of reset.
`define BMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bmp2rgba_pkg.sv =====
package bmp2rgba_pkg;

  localparam int MAX_DIMENSION_DEFAULT = 4096;

  // parse phases
  localparam logic [2:0] PH_SIGNATURE = 3'd0;
  localparam logic [2:0] PH_HEADER    = 3'd1;
  localparam logic [2:0] PH_SKIP      = 3'd2;
  localparam logic [2:0] PH_PIXELS    = 3'd3;
  localparam logic [2:0] PH_PADDING   = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NOT_BITMAP   = 3'd1;
  localparam logic [2:0] ERR_UNSUPPORTED  = 3'd2;
  localparam logic [2:0] ERR_HEADER_SIZE  = 3'd3;
  localparam logic [2:0] ERR_OFFSET       = 3'd4;
  localparam logic [2:0] ERR_TOO_LARGE    = 3'd5;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // signatures
  localparam logic [15:0] SIG_BM = 16'h424D;
  localparam logic [15:0] SIG_BA = 16'h4241;
  localparam logic [15:0] SIG_CI = 16'h4349;
  localparam logic [15:0] SIG_CP = 16'h4350;
  localparam logic [15:0] SIG_IC = 16'h4943;
  localparam logic [15:0] SIG_PT = 16'h5054;

  // header layout
  localparam logic [31:0] POS_FIELDS_FIRST = 32'd10;
  localparam logic [31:0] POS_FIELDS_LAST  = 32'd25;
  localparam logic [31:0] POS_HEADER_CHECK = 32'd17;
  localparam logic [31:0] INFO_HEADER_SIZE = 32'd40;
  localparam logic [31:0] MIN_PIXEL_OFFSET = 32'd54;

  localparam logic [1:0] FIELD_OFFSET = 2'd0;
  localparam logic [1:0] FIELD_HSIZE  = 2'd1;
  localparam logic [1:0] FIELD_WIDTH  = 2'd2;
  localparam logic [1:0] FIELD_HEIGHT = 2'd3;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

// ===== src/bmp_stream_to_rgba_core.sv =====
// Streaming decoder for 24-bit BMP files with a 40-byte info header. Feed the file one byte per
// transaction, with file_start high on its first byte (a high file_start restarts the parse at
// once). A new byte is taken every cycle as long as the result register is empty or being
// drained, so the sustained rate is one byte per clock; each third pixel byte yields one RGBA
// pixel result in the cycle after it is taken. Header problems yield a single error result
// (kind high), after which bytes are dropped until the next file_start. Rows come out in
// stored order, row padding is dropped, and the file ends on its last pixel.
`include "bmp_stream_to_rgba_core_macros.svh"

module bmp_stream_to_rgba_core
  import bmp2rgba_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [2:0]  error_code,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic        last_pixel
);

  localparam int CNT_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam logic [31:0] MAX_DIM = 32'(MAX_DIMENSION);

  logic [31:0]      byte_position, byte_position_next;
  logic [2:0]       phase, phase_next;
  logic [7:0]       first_sig, first_sig_next;
  logic [31:0]      pixel_offset, pixel_offset_next;
  logic [31:0]      header_length, header_length_next;
  logic [31:0]      image_width, image_width_next;
  logic [31:0]      image_height, image_height_next;
  logic [1:0]       channel_index, channel_index_next;
  logic [7:0]       held_blue, held_blue_next;
  logic [7:0]       held_green, held_green_next;
  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [1:0]       padding_left, padding_left_next;

  logic        accept;
  logic        take_pix;
  logic        res_valid;
  logic        res_kind;
  logic [2:0]  res_code;
  logic [7:0]  res_red;
  logic [7:0]  res_green;
  logic [7:0]  res_blue;
  logic [11:0] res_column;
  logic [11:0] res_row;
  logic        res_last;
  logic [15:0] signature;
  logic [4:0]  field_idx;
  logic        last_col;
  logic        last_row;
  logic [31:0] col_wide;
  logic [31:0] row_wide;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign alpha    = ALPHA_OPAQUE;

  always_comb begin
    byte_position_next = file_start ? '0 : byte_position;
    phase_next         = file_start ? PH_SIGNATURE : phase;
    first_sig_next     = file_start ? '0 : first_sig;
    pixel_offset_next  = file_start ? '0 : pixel_offset;
    header_length_next = file_start ? '0 : header_length;
    image_width_next   = file_start ? '0 : image_width;
    image_height_next  = file_start ? '0 : image_height;
    channel_index_next = file_start ? '0 : channel_index;
    held_blue_next     = file_start ? '0 : held_blue;
    held_green_next    = file_start ? '0 : held_green;
    column_count_next  = file_start ? '0 : column_count;
    row_count_next     = file_start ? '0 : row_count;
    padding_left_next  = file_start ? '0 : padding_left;

    take_pix   = 1'b0;
    res_valid  = 1'b0;
    res_kind   = KIND_PIXEL;
    res_code   = ERR_NONE;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_column = '0;
    res_row    = '0;
    res_last   = 1'b0;
    signature  = {first_sig_next, byte_value};
    field_idx  = byte_position_next[4:0] - POS_FIELDS_FIRST[4:0];
    last_col   = 1'b0;
    last_row   = 1'b0;
    col_wide   = 32'(column_count_next);
    row_wide   = 32'(row_count_next);

    unique case (phase_next)
      PH_SIGNATURE: begin
        if (byte_position_next == '0) begin
          first_sig_next     = byte_value;
          byte_position_next = 32'd1;
        end else begin
          byte_position_next = 32'd2;
          if (signature == SIG_BM) begin
            phase_next = PH_HEADER;
          end else begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            phase_next = PH_DONE;
            if (signature == SIG_BA || signature == SIG_CI || signature == SIG_CP ||
                signature == SIG_IC || signature == SIG_PT) begin
              res_code = ERR_UNSUPPORTED;
            end else begin
              res_code = ERR_NOT_BITMAP;
            end
          end
        end
      end
      PH_HEADER: begin
        if (byte_position_next >= POS_FIELDS_FIRST && byte_position_next <= POS_FIELDS_LAST)
        begin
          unique case (field_idx[3:2])
            FIELD_OFFSET: pixel_offset_next[{field_idx[1:0], 3'b000} +: 8]  = byte_value;
            FIELD_HSIZE:  header_length_next[{field_idx[1:0], 3'b000} +: 8] = byte_value;
            FIELD_WIDTH:  image_width_next[{field_idx[1:0], 3'b000} +: 8]   = byte_value;
            default:      image_height_next[{field_idx[1:0], 3'b000} +: 8]  = byte_value;
          endcase
        end
        if (byte_position_next == POS_HEADER_CHECK) begin
          if (header_length_next != INFO_HEADER_SIZE) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_code   = ERR_HEADER_SIZE;
            phase_next = PH_DONE;
          end else if (pixel_offset_next < MIN_PIXEL_OFFSET) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_code   = ERR_OFFSET;
            phase_next = PH_DONE;
          end
        end
        if (byte_position_next == POS_FIELDS_LAST) begin
          if (image_width_next > MAX_DIM || image_height_next > MAX_DIM) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_code   = ERR_TOO_LARGE;
            phase_next = PH_DONE;
          end else if (image_width_next == '0 || image_height_next == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        byte_position_next = byte_position_next + 32'd1;
      end
      PH_SKIP: begin
        if (byte_position_next == pixel_offset_next) begin
          phase_next = PH_PIXELS;
          take_pix   = 1'b1;
        end
        byte_position_next = byte_position_next + 32'd1;
      end
      PH_PIXELS: begin
        take_pix           = 1'b1;
        byte_position_next = byte_position_next + 32'd1;
      end
      PH_PADDING: begin
        padding_left_next  = padding_left_next - 2'd1;
        if (padding_left_next == '0) begin
          phase_next = PH_PIXELS;
        end
        byte_position_next = byte_position_next + 32'd1;
      end
      default: begin
      end
    endcase

    if (take_pix) begin
      priority if (channel_index_next == CH_BLUE) begin
        held_blue_next     = byte_value;
        channel_index_next = CH_GREEN;
      end else if (channel_index_next == CH_GREEN) begin
        held_green_next    = byte_value;
        channel_index_next = CH_RED;
      end else begin
        channel_index_next = CH_BLUE;
        last_col   = (col_wide == image_width_next - 32'd1);
        last_row   = (row_wide == image_height_next - 32'd1);
        res_valid  = 1'b1;
        res_kind   = KIND_PIXEL;
        res_red    = byte_value;
        res_green  = held_green_next;
        res_blue   = held_blue_next;
        res_column = col_wide[11:0];
        res_row    = row_wide[11:0];
        res_last   = last_col && last_row;
        if (last_col) begin
          if (last_row) begin
            phase_next = PH_DONE;
          end else begin
            column_count_next = '0;
            row_count_next    = row_count_next + CNT_W'(1);
            padding_left_next = image_width_next[1:0];
            if (padding_left_next != '0) begin
              phase_next = PH_PADDING;
            end
          end
        end else begin
          column_count_next = column_count_next + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      phase         <= PH_SIGNATURE;
      first_sig     <= '0;
      pixel_offset  <= '0;
      header_length <= '0;
      image_width   <= '0;
      image_height  <= '0;
      channel_index <= '0;
      held_blue     <= '0;
      held_green    <= '0;
      column_count  <= '0;
      row_count     <= '0;
      padding_left  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= byte_position_next;
        phase         <= phase_next;
        first_sig     <= first_sig_next;
        pixel_offset  <= pixel_offset_next;
        header_length <= header_length_next;
        image_width   <= image_width_next;
        image_height  <= image_height_next;
        channel_index <= channel_index_next;
        held_blue     <= held_blue_next;
        held_green    <= held_green_next;
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        padding_left  <= padding_left_next;
      end
      if (accept && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind       <= res_kind;
      error_code <= res_code;
      red        <= res_red;
      green      <= res_green;
      blue       <= res_blue;
      column     <= res_column;
      row        <= res_row;
      last_pixel <= res_last;
    end
  end

  `BMP_ASSERT(a_error_ends_file, accept && res_valid && res_kind |=> phase == PH_DONE, "error result did not end the file")
  `BMP_ASSERT(a_kind_matches_code, out_valid |-> (kind == (error_code != ERR_NONE)), "result kind and error code disagree")
  `BMP_ASSERT(a_last_is_pixel, out_valid && last_pixel |-> kind == KIND_PIXEL, "last pixel flag on an error result")
  `BMP_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty result register")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bmp2rgba_pkg::*;

  localparam int MAX_DIM = MAX_DIMENSION_DEFAULT;
  localparam int RANDOM_BYTES = 150;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int WHOLE_FILE = 1 << 30;
  localparam int BYTE_CAP = 20000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  err;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
  } rgba_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_value = 8'd0;
  logic        file_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [2:0]  error_code;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [11:0] column;
  logic [11:0] row;
  logic        last_pixel;

  logic        steady = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;

  rgba_result_t expected_rgba[$];
  logic [7:0]   file_bytes[$];

  logic [31:0] cur_pos;
  logic [31:0] offset_word;
  logic [31:0] hsize_word;
  logic [31:0] width_word;
  logic [31:0] height_word;
  logic [2:0]  phase;
  logic [7:0]  sig_first;
  logic [7:0]  blue_hold;
  logic [7:0]  green_hold;
  logic [1:0]  chan;
  logic [1:0]  pad_left;
  logic [11:0] col_cnt;
  logic [11:0] row_cnt;

  initial begin
    forever #1 clk = ~clk;
  end

  bmp_stream_to_rgba_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .file_start (file_start),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .error_code (error_code),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha),
    .column     (column),
    .row        (row),
    .last_pixel (last_pixel)
  );

  function automatic void clear_parse();
    cur_pos = '0;
    phase = PH_SIGNATURE;
    sig_first = '0;
    offset_word = '0;
    hsize_word = '0;
    width_word = '0;
    height_word = '0;
    chan = CH_BLUE;
    blue_hold = '0;
    green_hold = '0;
    col_cnt = '0;
    row_cnt = '0;
    pad_left = '0;
  endfunction

  function automatic string fmt_rgba(rgba_result_t r);
    return $sformatf("kind=%0d err=%0d rgba=%02x_%02x_%02x_%02x col=%0d row=%0d last=%0d",
                     r.kind, r.err, r.red, r.green, r.blue, r.alpha, r.col, r.row, r.last);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [31:0]  pos;
    logic [31:0]  rel;
    logic [31:0]  pad_word;
    logic [15:0]  sig;
    logic [2:0]   err;
    logic         pix;
    logic         produced;
    logic         last_col;
    logic         last_row;
    rgba_result_t r;
    if (start) clear_parse();
    pos = cur_pos;
    pix = 1'b0;
    produced = 1'b0;
    err = ERR_NONE;
    r = '0;
    r.alpha = ALPHA_OPAQUE;
    case (phase)
      PH_SIGNATURE: begin
        if (pos == 0) begin
          sig_first = b;
          cur_pos = 32'd1;
        end else begin
          cur_pos = 32'd2;
          sig = {sig_first, b};
          if (sig == SIG_BM) phase = PH_HEADER;
          else if (sig == SIG_BA || sig == SIG_CI || sig == SIG_CP || sig == SIG_IC ||
                   sig == SIG_PT) err = ERR_UNSUPPORTED;
          else err = ERR_NOT_BITMAP;
        end
      end
      PH_HEADER: begin
        cur_pos = pos + 32'd1;
        if (pos >= POS_FIELDS_FIRST && pos <= POS_FIELDS_LAST) begin
          rel = pos - POS_FIELDS_FIRST;
          case (rel[3:2])
            FIELD_OFFSET: offset_word[rel[1:0] * 8 +: 8] = b;
            FIELD_HSIZE:  hsize_word[rel[1:0] * 8 +: 8] = b;
            FIELD_WIDTH:  width_word[rel[1:0] * 8 +: 8] = b;
            default:      height_word[rel[1:0] * 8 +: 8] = b;
          endcase
        end
        if (pos == POS_HEADER_CHECK) begin
          if (hsize_word != INFO_HEADER_SIZE) err = ERR_HEADER_SIZE;
          else if (offset_word < MIN_PIXEL_OFFSET) err = ERR_OFFSET;
        end
        if (pos == POS_FIELDS_LAST) begin
          if (width_word > MAX_DIM || height_word > MAX_DIM) err = ERR_TOO_LARGE;
          else if (width_word == 0 || height_word == 0) phase = PH_DONE;
          else phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        cur_pos = pos + 32'd1;
        if (pos == offset_word) begin
          phase = PH_PIXELS;
          pix = 1'b1;
        end
      end
      PH_PIXELS: begin
        cur_pos = pos + 32'd1;
        pix = 1'b1;
      end
      PH_PADDING: begin
        cur_pos = pos + 32'd1;
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) phase = PH_PIXELS;
      end
      default: ;
    endcase
    if (pix) begin
      if (chan == CH_BLUE) begin
        blue_hold = b;
        chan = CH_GREEN;
      end else if (chan == CH_GREEN) begin
        green_hold = b;
        chan = CH_RED;
      end else begin
        chan = CH_BLUE;
        last_col = ({20'd0, col_cnt} == width_word - 32'd1);
        last_row = ({20'd0, row_cnt} == height_word - 32'd1);
        r.kind = KIND_PIXEL;
        r.err = ERR_NONE;
        r.red = b;
        r.green = green_hold;
        r.blue = blue_hold;
        r.col = col_cnt;
        r.row = row_cnt;
        r.last = last_col && last_row;
        produced = 1'b1;
        if (last_col) begin
          if (last_row) begin
            phase = PH_DONE;
          end else begin
            col_cnt = '0;
            row_cnt = row_cnt + 12'd1;
            pad_word = 32'd0 - 32'd3 * width_word;
            pad_left = pad_word[1:0];
            if (pad_left != 2'd0) phase = PH_PADDING;
          end
        end else begin
          col_cnt = col_cnt + 12'd1;
        end
      end
    end
    if (err != ERR_NONE) begin
      r.kind = KIND_ERROR;
      r.err = err;
      produced = 1'b1;
      phase = PH_DONE;
    end
    if (produced) expected_rgba.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_value <= b;
    file_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    decode_byte(b, start);
  endtask

  task automatic send_stream(input logic first_start, input int count);
    int n;
    n = (count < file_bytes.size()) ? count : file_bytes.size();
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], (i == 0) ? first_start : 1'b0);
  endtask

  task automatic build_bmp(input logic [15:0] sig, input logic [31:0] offset,
                           input logic [31:0] hsize, input logic [31:0] width,
                           input logic [31:0] height);
    int hdr_len;
    int pad;
    file_bytes.delete();
    hdr_len = (offset >= 26 && offset <= 300) ? offset : 54;
    repeat (hdr_len) file_bytes.push_back(8'($urandom));
    file_bytes[0] = sig[15:8];
    file_bytes[1] = sig[7:0];
    for (int k = 0; k < 4; k++) begin
      file_bytes[10 + k] = offset[8 * k +: 8];
      file_bytes[14 + k] = hsize[8 * k +: 8];
      file_bytes[18 + k] = width[8 * k +: 8];
      file_bytes[22 + k] = height[8 * k +: 8];
    end
    if (width != 0 && height != 0 && width <= MAX_DIM && height <= MAX_DIM) begin
      pad = (4 - (width * 3) % 4) % 4;
      for (int rr = 0; rr < height && file_bytes.size() < BYTE_CAP; rr++) begin
        repeat (width * 3) file_bytes.push_back(8'($urandom));
        if (rr != height - 1) repeat (pad) file_bytes.push_back(8'($urandom));
      end
    end else begin
      repeat (6) file_bytes.push_back(8'($urandom));
    end
    // trailing bytes past the end of the image
    repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
  endtask

  task automatic send_bmp_part(input logic [15:0] sig, input logic [31:0] offset,
                               input logic [31:0] hsize, input logic [31:0] width,
                               input logic [31:0] height, input int count);
    build_bmp(sig, offset, hsize, width, height);
    send_stream(1'b1, count);
  endtask

  task automatic send_bmp(input logic [15:0] sig, input logic [31:0] offset,
                          input logic [31:0] hsize, input logic [31:0] width,
                          input logic [31:0] height);
    send_bmp_part(sig, offset, hsize, width, height, WHOLE_FILE);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rgba.size() != 0) @(posedge clk);
  endtask

  task automatic test_first_file_without_start();
    build_bmp(SIG_BM, 54, INFO_HEADER_SIZE, 2, 2);
    for (int k = 0; k < 6; k++) file_bytes[54 + k] = k[0] ? 8'hFF : 8'h00;
    send_stream(1'b0, WHOLE_FILE);
  endtask

  task automatic test_signatures();
    logic [15:0] sig_list [0:9];
    sig_list = '{SIG_BA, SIG_CI, SIG_CP, SIG_IC, SIG_PT,
                 16'h424E, 16'h4D42, 16'h0000, 16'hFFFF, 16'h4142};
    foreach (sig_list[k]) send_bmp_part(sig_list[k], 54, INFO_HEADER_SIZE, 2, 1, 3);
  endtask

  task automatic test_header_errors();
    send_bmp_part(SIG_BM, 54, 32'd0, 2, 2, 18);
    send_bmp_part(SIG_BM, 54, 32'd39, 2, 2, 18);
    send_bmp_part(SIG_BM, 54, 32'd41, 2, 2, 18);
    send_bmp_part(SIG_BM, 54, 32'hFFFF_FFFF, 2, 2, 18);
    send_bmp_part(SIG_BM, 10, 32'd39, 2, 2, 18);
    send_bmp_part(SIG_BM, 0, INFO_HEADER_SIZE, 2, 2, 18);
    send_bmp_part(SIG_BM, 53, INFO_HEADER_SIZE, 2, 2, 18);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, MAX_DIM + 1, 1, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 1, MAX_DIM + 1, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 32'h8000_0000, 1, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 0, MAX_DIM + 1, 26);
  endtask

  task automatic test_empty_images();
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 0, 3, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 3, 0, 26);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 0, 0, 26);
    send_bmp(SIG_BM, 56, INFO_HEADER_SIZE, 1, 1);
  endtask

  task automatic test_restart_mid_file();
    int cuts [0:4];
    cuts = '{1, 12, 30, 64, 71};
    foreach (cuts[k]) begin
      build_bmp(SIG_BM, 60, INFO_HEADER_SIZE, 3, 3);
      send_stream(1'b1, cuts[k]);
    end
  endtask

  task automatic test_max_dimensions();
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, MAX_DIM, 1, 72);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, 1, MAX_DIM, 72);
    send_bmp_part(SIG_BM, 54, INFO_HEADER_SIZE, MAX_DIM, MAX_DIM, 72);
  endtask

  task automatic test_steady_stream();
    steady <= 1'b1;
    repeat (2) send_bmp(SIG_BM, $urandom_range(54, 64), INFO_HEADER_SIZE,
                        $urandom_range(1, 7), $urandom_range(1, 4));
    steady <= 1'b0;
  endtask

  task automatic test_output_backpressure();
    build_bmp(SIG_BM, 54, INFO_HEADER_SIZE, 3, 3);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      send_stream(1'b1, WHOLE_FILE);
    join
    // hold the sender until the block is empty
    wait_drained();
    send_bmp(SIG_BM, 58, INFO_HEADER_SIZE, 1, 1);
  endtask

  task automatic test_random_files();
    int unsigned start_count;
    int unsigned pick;
    int          count;
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [31:0] hs;
    logic [31:0] big;
    logic [15:0] sig;
    logic [15:0] variants [0:4];
    variants = '{SIG_BA, SIG_CI, SIG_CP, SIG_IC, SIG_PT};
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      pick = $urandom_range(99);
      if (pick >= 94) begin
        repeat ($urandom_range(10, 40)) send_byte(8'($urandom), $urandom_range(7) == 0);
      end else if (pick >= 91) begin
        wait_drained();
      end else begin
        sig = SIG_BM;
        hs = INFO_HEADER_SIZE;
        off = $urandom_range(54, 72);
        w = $urandom_range(1, 7);
        h = $urandom_range(1, 4);
        if (pick >= 72 && pick < 76) begin
          sig = $urandom_range(1) ? variants[$urandom_range(4)] : 16'($urandom);
        end else if (pick >= 76 && pick < 80) begin
          hs = $urandom_range(1) ? $urandom : $urandom_range(36, 44);
          if (hs == INFO_HEADER_SIZE) hs = 32'd0;
        end else if (pick >= 80 && pick < 84) begin
          off = $urandom_range(53);
        end else if (pick >= 84 && pick < 88) begin
          big = $urandom_range(1) ? MAX_DIM + 1 : $urandom;
          if (big <= MAX_DIM) big = MAX_DIM + 1;
          if ($urandom_range(1)) w = big;
          else h = big;
        end else if (pick >= 88) begin
          if ($urandom_range(1)) w = 32'd0;
          else h = 32'd0;
        end
        build_bmp(sig, off, hs, w, h);
        count = (pick >= 65 && pick < 72) ? $urandom_range(1, file_bytes.size() - 1)
                                          : WHOLE_FILE;
        send_stream($urandom_range(15) != 0, count);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || rx_hold) out_ready <= 1'b0;
    else if (steady) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin : check_results
    rgba_result_t got;
    rgba_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {kind, error_code, red, green, blue, alpha, column, row, last_pixel};
      if (expected_rgba.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected transaction %s", $time, fmt_rgba(got));
      end else begin
        want = expected_rgba.pop_front();
        if (got.kind !== want.kind || got.err !== want.err || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.col !== want.col || got.row !== want.row ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch expected %s got %s", $time, fmt_rgba(want),
                     fmt_rgba(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_parse();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_first_file_without_start();
    test_signatures();
    test_header_errors();
    test_empty_images();
    test_restart_mid_file();
    test_max_dimensions();
    test_steady_stream();
    test_output_backpressure();
    test_random_files();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_rgba.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
